// ----- rtl/core/mtep_pkg.sv -----
// shared types and constants for the midi track event parser
// result word layout, queue entry layout, parser phase codes
// no dependencies
package mtep_pkg;

  // queue between the parser front and the result back end
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // lead and meta type bytes
  localparam logic [7:0] LEAD_SYSEX  = 8'hf0;
  localparam logic [7:0] LEAD_ESC    = 8'hf7;
  localparam logic [7:0] LEAD_META   = 8'hff;
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_PROG     = 4'hc;
  localparam logic [3:0] HI_PRESS    = 4'hd;
  localparam logic [3:0] HI_SYSTEM   = 4'hf;
  localparam logic [7:0] VEL_DEFAULT = 8'h40;
  localparam logic [7:0] META_PREFIX = 8'h20;
  localparam logic [7:0] META_EOT    = 8'h2f;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] PREFIX_NONE = 8'hff;
  localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
  localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;

  // result kinds
  typedef enum logic [2:0] {
    KIND_DELAY   = 3'd0,
    KIND_CHANNEL = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_TEMPO   = 3'd4,
    KIND_EOT     = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NO_STATUS  = 2'd0,
    ERR_BAD_STATUS = 2'd1,
    ERR_TRUNCATED  = 2'd2,
    ERR_TOO_LONG   = 2'd3
  } errc_t;

  // parser phases, one-hot
  typedef enum logic [7:0] {
    PH_DELTA   = 8'b0000_0001,
    PH_LEAD    = 8'b0000_0010,
    PH_DATA1   = 8'b0000_0100,
    PH_DATA2   = 8'b0000_1000,
    PH_MTYPE   = 8'b0001_0000,
    PH_LEN     = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [27:0] ticks;
    logic [7:0]  opcode;
    logic [7:0]  channel;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [7:0]  block_type;
    logic [27:0] block_length;
    logic [7:0]  payload_value;
    logic [23:0] tempo_us;
    errc_t       error_code;
    logic        last;
  } res_t;

  // results of one input byte; a second result is always tempo, end or error
  typedef struct packed {
    res_t        r0;
    logic        has2;
    kind_t       k1;
    logic [23:0] tempo1;
    errc_t       err1;
  } q_ent_t;

endpackage

// ----- rtl/core/mtep_front.sv -----
// parser front: accepts one track byte per cycle when fire is high,
// updates the parse state and forms the byte's results as one queue entry
// depends on mtep_pkg
module mtep_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            track_start,
  input  logic            track_last,
  output logic            push,
  output mtep_pkg::q_ent_t push_ent
);
  import mtep_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [27:0] acc_r, acc_nxt;
  logic [2:0]  lbytes_r, lbytes_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [7:0]  fdata_r, fdata_nxt;
  logic [7:0]  meta_r, meta_nxt;
  logic [27:0] left_r, left_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic        over_r, over_nxt;

  // state as seen by this byte, after a track start
  phase_t      c_phase;
  logic [7:0]  c_rstat, c_prefix, c_lead, c_fdata, c_meta;
  logic [27:0] c_acc, c_left;
  logic [2:0]  c_lbytes;
  logic [1:0]  c_pidx;
  logic [23:0] c_tempo;
  logic        c_over;

  res_t        r0, r1;
  logic [1:0]  cnt;

  assign c_phase  = track_start ? PH_DELTA    : phase_r;
  assign c_rstat  = track_start ? 8'h00       : rstat_r;
  assign c_prefix = track_start ? PREFIX_NONE : prefix_r;
  assign c_acc    = track_start ? 28'd0       : acc_r;
  assign c_lbytes = track_start ? 3'd0        : lbytes_r;
  assign c_lead   = track_start ? 8'h00       : lead_r;
  assign c_fdata  = track_start ? 8'h00       : fdata_r;
  assign c_meta   = track_start ? 8'h00       : meta_r;
  assign c_left   = track_start ? 28'd0       : left_r;
  assign c_pidx   = track_start ? 2'd0        : pidx_r;
  assign c_tempo  = track_start ? 24'd0       : tempo_r;
  assign c_over   = track_start ? 1'b0        : over_r;

  // byte step
  always_comb begin
    logic [27:0] acc;
    logic [2:0]  lb;
    logic [7:0]  lead;
    logic        is_data;
    logic        do_chan;
    logic [7:0]  chan_a;
    logic [7:0]  chan_b;
    logic [3:0]  hi;
    logic        do_finish;

    acc       = {c_acc[20:0], data_byte[6:0]};
    lb        = c_lbytes + 3'd1;
    lead      = c_lead;
    is_data   = 1'b0;
    do_chan   = 1'b0;
    chan_a    = 8'h00;
    chan_b    = 8'h00;
    hi        = 4'h0;
    do_finish = 1'b0;

    phase_nxt  = c_phase;
    rstat_nxt  = c_rstat;
    prefix_nxt = c_prefix;
    acc_nxt    = c_acc;
    lbytes_nxt = c_lbytes;
    lead_nxt   = c_lead;
    fdata_nxt  = c_fdata;
    meta_nxt   = c_meta;
    left_nxt   = c_left;
    pidx_nxt   = c_pidx;
    tempo_nxt  = c_tempo;
    over_nxt   = c_over;
    r0  = '0;
    r1  = '0;
    cnt = 2'd0;

    if (!c_over && c_phase != PH_ERROR) begin
      case (c_phase)
        PH_DELTA: begin
          acc_nxt    = acc;
          lbytes_nxt = lb;
          if (data_byte[7]) begin
            if (lb >= VLQ_MAX_BYTES) begin
              r0.kind       = KIND_ERROR;
              r0.error_code = ERR_TOO_LONG;
              cnt           = 2'd1;
              phase_nxt     = PH_ERROR;
            end
          end else begin
            if (!track_last && acc != 28'd0) begin
              r0.kind  = KIND_DELAY;
              r0.ticks = acc;
              cnt      = 2'd1;
            end
            acc_nxt    = 28'd0;
            lbytes_nxt = 3'd0;
            phase_nxt  = track_last ? PH_DELTA : PH_LEAD;
          end
        end
        PH_LEAD: begin
          if (data_byte[7] || c_rstat != 8'h00) begin
            if (data_byte[7]) begin
              lead = data_byte;
            end else begin
              lead    = c_rstat;
              is_data = 1'b1;
            end
            lead_nxt = lead;
            if (lead[7:4] == HI_SYSTEM) begin
              rstat_nxt = 8'h00;
              if (lead == LEAD_META) begin
                phase_nxt = PH_MTYPE;
              end else if (lead == LEAD_SYSEX || lead == LEAD_ESC) begin
                meta_nxt   = 8'h00;
                acc_nxt    = 28'd0;
                lbytes_nxt = 3'd0;
                phase_nxt  = PH_LEN;
              end else begin
                r0.kind       = KIND_ERROR;
                r0.error_code = ERR_BAD_STATUS;
                cnt           = 2'd1;
                phase_nxt     = PH_ERROR;
              end
            end else begin
              rstat_nxt = lead;
              if (is_data) begin
                if (lead[7:4] == HI_PROG || lead[7:4] == HI_PRESS) begin
                  do_chan = 1'b1;
                  chan_a  = data_byte;
                end else begin
                  fdata_nxt = data_byte;
                  phase_nxt = PH_DATA2;
                end
              end else begin
                phase_nxt = PH_DATA1;
              end
            end
          end else begin
            r0.kind       = KIND_ERROR;
            r0.error_code = ERR_NO_STATUS;
            cnt           = 2'd1;
            phase_nxt     = PH_ERROR;
          end
        end
        PH_DATA1: begin
          if (c_lead[7:4] == HI_PROG || c_lead[7:4] == HI_PRESS) begin
            do_chan = 1'b1;
            chan_a  = data_byte;
          end else begin
            fdata_nxt = data_byte;
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          do_chan = 1'b1;
          chan_a  = c_fdata;
          chan_b  = data_byte;
        end
        PH_MTYPE: begin
          meta_nxt   = data_byte;
          acc_nxt    = 28'd0;
          lbytes_nxt = 3'd0;
          phase_nxt  = PH_LEN;
        end
        PH_LEN: begin
          acc_nxt    = acc;
          lbytes_nxt = lb;
          if (data_byte[7]) begin
            if (lb >= VLQ_MAX_BYTES) begin
              r0.kind       = KIND_ERROR;
              r0.error_code = ERR_TOO_LONG;
              cnt           = 2'd1;
              phase_nxt     = PH_ERROR;
            end
          end else begin
            r0.kind         = KIND_HEADER;
            r0.opcode       = c_lead;
            r0.channel      = c_prefix;
            r0.block_type   = c_meta;
            r0.block_length = acc;
            cnt             = 2'd1;
            left_nxt        = acc;
            pidx_nxt        = 2'd0;
            tempo_nxt       = 24'd0;
            if (acc == 28'd0) begin
              do_finish = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          r0.kind          = KIND_PAYLOAD;
          r0.payload_value = data_byte;
          cnt              = 2'd1;
          if (c_lead == LEAD_META) begin
            if (c_meta == META_PREFIX && c_pidx == 2'd0) begin
              prefix_nxt = data_byte;
            end
            if (c_meta == META_TEMPO && c_pidx != 2'd3) begin
              tempo_nxt = {c_tempo[15:0], data_byte};
            end
          end
          if (c_pidx != 2'd3) begin
            pidx_nxt = c_pidx + 2'd1;
          end
          left_nxt = c_left - 28'd1;
          if (c_left == 28'd1) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase

      // channel event, with note on at zero velocity turned into note off
      if (do_chan) begin
        hi = lead_nxt[7:4];
        if (hi == HI_NOTE_ON && chan_b == 8'h00) begin
          hi     = HI_NOTE_OFF;
          chan_b = VEL_DEFAULT;
        end
        r0.kind    = KIND_CHANNEL;
        r0.opcode  = {hi, 4'h0};
        r0.channel = {4'h0, lead_nxt[3:0]};
        r0.data_a  = chan_a;
        r0.data_b  = chan_b;
        cnt        = 2'd1;
        phase_nxt  = PH_DELTA;
        acc_nxt    = 28'd0;
        lbytes_nxt = 3'd0;
      end

      // end of a sysex or meta block
      if (do_finish) begin
        phase_nxt  = PH_DELTA;
        acc_nxt    = 28'd0;
        lbytes_nxt = 3'd0;
        if (lead_nxt == LEAD_META) begin
          if (meta_nxt == META_EOT) begin
            r1.kind  = KIND_EOT;
            cnt      = 2'd2;
            over_nxt = 1'b1;
          end else if (meta_nxt == META_TEMPO && pidx_nxt == 2'd3) begin
            r1.kind     = KIND_TEMPO;
            r1.tempo_us = (tempo_nxt != 24'd0) ? tempo_nxt : TEMPO_DEFAULT;
            cnt         = 2'd2;
          end
        end
      end

      // track ended with something unfinished
      if (track_last && !over_nxt && phase_nxt != PH_ERROR &&
          (phase_nxt != PH_DELTA || lbytes_nxt != 3'd0)) begin
        if (cnt == 2'd0) begin
          r0.kind       = KIND_ERROR;
          r0.error_code = (phase_nxt == PH_PAYLOAD) ? ERR_TOO_LONG : ERR_TRUNCATED;
          cnt           = 2'd1;
        end else begin
          r1.kind       = KIND_ERROR;
          r1.error_code = (phase_nxt == PH_PAYLOAD) ? ERR_TOO_LONG : ERR_TRUNCATED;
          cnt           = 2'd2;
        end
        phase_nxt = PH_ERROR;
      end
    end
  end

  // queue entry for this byte
  always_comb begin
    push_ent         = '0;
    push_ent.r0      = r0;
    push_ent.r0.last = (cnt == 2'd1);
    push_ent.has2    = (cnt == 2'd2);
    push_ent.k1      = r1.kind;
    push_ent.tempo1  = r1.tempo_us;
    push_ent.err1    = r1.error_code;
  end

  assign push = fire && (cnt != 2'd0);

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      rstat_r  <= 8'h00;
      prefix_r <= PREFIX_NONE;
      acc_r    <= 28'd0;
      lbytes_r <= 3'd0;
      lead_r   <= 8'h00;
      fdata_r  <= 8'h00;
      meta_r   <= 8'h00;
      left_r   <= 28'd0;
      pidx_r   <= 2'd0;
      tempo_r  <= 24'd0;
      over_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      rstat_r  <= rstat_nxt;
      prefix_r <= prefix_nxt;
      acc_r    <= acc_nxt;
      lbytes_r <= lbytes_nxt;
      lead_r   <= lead_nxt;
      fdata_r  <= fdata_nxt;
      meta_r   <= meta_nxt;
      left_r   <= left_nxt;
      pidx_r   <= pidx_nxt;
      tempo_r  <= tempo_nxt;
      over_r   <= over_nxt;
    end
  end

endmodule

// ----- rtl/core/mtep_queue.sv -----
// short queue of per-byte result entries between parser front and back end
// depends on mtep_pkg
module mtep_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtep_pkg::q_ent_t push_ent,
  input  logic             pop,
  output logic             full,
  output logic             nempty,
  output mtep_pkg::q_ent_t head
);
  import mtep_pkg::*;

  q_ent_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full   = (cnt_r == QCNT_W'(QDEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem_r[rptr_r];
  assign do_pop = pop && nempty;

  // pointers wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ent;
    end
  end

endmodule

// ----- rtl/core/mtep_back.sv -----
// back end: splits each queue entry into result words and drives the
// registered output channel
// depends on mtep_pkg
module mtep_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nempty,
  input  mtep_pkg::q_ent_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mtep_pkg::res_t   out_res
);
  import mtep_pkg::*;

  logic  sel_r, sel_nxt;
  logic  valid_r, valid_nxt;
  res_t  res_r, res_nxt;
  logic  load;

  assign load = !valid_r || out_ready;

  // pick the next word of the head entry
  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    if (load) begin
      valid_nxt = q_nempty;
      if (q_nempty) begin
        if (!sel_r) begin
          res_nxt      = q_head.r0;
          res_nxt.last = !q_head.has2;
          sel_nxt      = q_head.has2;
          q_pop        = !q_head.has2;
        end else begin
          res_nxt            = '0;
          res_nxt.kind       = q_head.k1;
          res_nxt.tempo_us   = q_head.tempo1;
          res_nxt.error_code = q_head.err1;
          res_nxt.last       = 1'b1;
          sel_nxt            = 1'b0;
          q_pop              = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/core/midi_track_event_parser.sv -----
// midi track event parser, top level: one track body byte per cycle in while
// the queue is not full; result words pass through the queue and output register
// throughput: one byte per cycle while not full, one result word per cycle while
//   out_tready is high; extra result words are absorbed by a four-entry queue
// reset: rst_n synchronous active low clears parse state, queue and output valid
module midi_track_event_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // track_start
  input  logic         in_tlast,   // track_last
  output logic         out_tvalid,
  input  logic         out_tready,
  // ticks, opcode, channel, data_a, data_b, block_type, block_length,
  // payload_value, tempo_us, error_code, zero fill
  output logic [135:0] out_tdata,
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast   // last
);
  import mtep_pkg::*;

  logic   fire;
  logic   push;
  q_ent_t push_ent;
  logic   q_full;
  logic   q_nempty;
  logic   q_pop;
  q_ent_t q_head;
  res_t   res;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  mtep_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_tdata),
    .track_start (in_tuser),
    .track_last  (in_tlast),
    .push        (push),
    .push_ent    (push_ent)
  );

  mtep_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (q_head)
  );

  mtep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_nempty  (q_nempty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result word
  assign out_tdata = {6'b0, res.error_code, res.tempo_us, res.payload_value,
                      res.block_length, res.block_type, res.data_b, res.data_a,
                      res.channel, res.opcode, res.ticks};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ----- test/tb.sv -----
// self-checking testbench for midi_track_event_parser: directed table, then random tracks
// results are predicted per accepted byte and compared word by word; needs mtep_pkg only
`timescale 1ns / 100ps

module tb;
  import mtep_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 1150;
  localparam int DIR_ROWS     = 35;

  // one stimulus byte; a typed row carries its single expected word
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        fin;
    logic        typed;
    kind_t       tkind;
    logic [27:0] tticks;
    errc_t       terr;
  } item_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;   // ticks, opcode, channel, data_a, data_b, block_type,
                             // block_length, payload_value, tempo_us, error_code, zero fill
  logic [2:0]   out_tuser;   // kind
  logic         out_tlast;   // last

  midi_track_event_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  item_t stim_q[$];
  item_t cur_item = '0;
  res_t  expected_words[$];
  res_t  byte_words[$];
  int    send_idle = 0;
  int    stall_pct = 0;
  int    quiet_cycles = 0;
  int    fail_count = 0;
  int    bytes_taken = 0;
  int    words_checked = 0;
  int    kind_seen[8];

  // ---------------------------------------------------------------- parser copy
  phase_t      st_phase;
  logic [7:0]  run_status;
  logic [7:0]  prefix;
  logic [27:0] vlq_acc;
  logic [2:0]  vlq_cnt;
  logic [7:0]  lead;
  logic [7:0]  held_data;
  logic [7:0]  meta_type;
  logic [27:0] left;
  logic [1:0]  pay_idx;
  logic [23:0] tempo_acc;
  logic        ended;

  task automatic clear_parser();
    st_phase = PH_DELTA;
    run_status = 8'h00;
    prefix = PREFIX_NONE;
    vlq_acc = '0;
    vlq_cnt = '0;
    lead = 8'h00;
    held_data = 8'h00;
    meta_type = 8'h00;
    left = '0;
    pay_idx = '0;
    tempo_acc = '0;
    ended = 1'b0;
  endtask

  function automatic res_t blank_word(kind_t k);
    res_t w;
    w = '0;
    w.kind = k;
    return w;
  endfunction

  task automatic raise_error(errc_t c);
    res_t w;
    w = blank_word(KIND_ERROR);
    w.error_code = c;
    byte_words.push_back(w);
    st_phase = PH_ERROR;
  endtask

  task automatic back_to_delta();
    st_phase = PH_DELTA;
    vlq_acc = '0;
    vlq_cnt = '0;
  endtask

  // note on with zero velocity turns into note off at default velocity
  task automatic emit_channel(logic [7:0] a, logic [7:0] b);
    res_t w;
    logic [3:0] hi;
    logic [7:0] vb;
    hi = lead[7:4];
    vb = b;
    if (hi == HI_NOTE_ON && vb == 8'h00) begin
      hi = HI_NOTE_OFF;
      vb = VEL_DEFAULT;
    end
    w = blank_word(KIND_CHANNEL);
    w.opcode = {hi, 4'h0};
    w.channel = {4'h0, lead[3:0]};
    w.data_a = a;
    w.data_b = vb;
    byte_words.push_back(w);
    back_to_delta();
  endtask

  task automatic take_first_data(logic [7:0] b);
    if (lead[7:4] == HI_PROG || lead[7:4] == HI_PRESS) begin
      emit_channel(b, 8'h00);
    end else begin
      held_data = b;
      st_phase = PH_DATA2;
    end
  endtask

  task automatic close_block();
    res_t w;
    back_to_delta();
    if (lead == LEAD_META) begin
      if (meta_type == META_EOT) begin
        byte_words.push_back(blank_word(KIND_EOT));
        ended = 1'b1;
      end else if (meta_type == META_TEMPO && pay_idx >= 2'd3) begin
        w = blank_word(KIND_TEMPO);
        w.tempo_us = (tempo_acc != 0) ? tempo_acc : TEMPO_DEFAULT;
        byte_words.push_back(w);
      end
    end
  endtask

  // words caused by one track byte land in byte_words, last one marked
  task automatic parse_track_byte(logic [7:0] b, logic start, logic fin);
    res_t w;
    logic [7:0] ld;
    logic is_data;
    byte_words.delete();
    if (start) clear_parser();
    if (!ended && st_phase != PH_ERROR) begin
      case (st_phase)
        PH_DELTA: begin
          vlq_acc = {vlq_acc[20:0], b[6:0]};
          vlq_cnt = vlq_cnt + 3'd1;
          if (b[7]) begin
            if (vlq_cnt >= VLQ_MAX_BYTES) raise_error(ERR_TOO_LONG);
          end else begin
            if (!fin && vlq_acc != 0) begin
              w = blank_word(KIND_DELAY);
              w.ticks = vlq_acc;
              byte_words.push_back(w);
            end
            back_to_delta();
            if (!fin) st_phase = PH_LEAD;
          end
        end
        PH_LEAD: begin
          is_data = 1'b0;
          ld = b;
          if (!b[7]) begin
            ld = run_status;
            is_data = 1'b1;
          end
          if (!b[7] && run_status == 8'h00) begin
            raise_error(ERR_NO_STATUS);
          end else begin
            lead = ld;
            if (ld[7:4] == HI_SYSTEM) begin
              run_status = 8'h00;
              if (ld == LEAD_META) begin
                st_phase = PH_MTYPE;
              end else if (ld == LEAD_SYSEX || ld == LEAD_ESC) begin
                meta_type = 8'h00;
                vlq_acc = '0;
                vlq_cnt = '0;
                st_phase = PH_LEN;
              end else begin
                raise_error(ERR_BAD_STATUS);
              end
            end else begin
              run_status = ld;
              if (is_data) take_first_data(b);
              else st_phase = PH_DATA1;
            end
          end
        end
        PH_DATA1: take_first_data(b);
        PH_DATA2: emit_channel(held_data, b);
        PH_MTYPE: begin
          meta_type = b;
          vlq_acc = '0;
          vlq_cnt = '0;
          st_phase = PH_LEN;
        end
        PH_LEN: begin
          vlq_acc = {vlq_acc[20:0], b[6:0]};
          vlq_cnt = vlq_cnt + 3'd1;
          if (b[7]) begin
            if (vlq_cnt >= VLQ_MAX_BYTES) raise_error(ERR_TOO_LONG);
          end else begin
            w = blank_word(KIND_HEADER);
            w.opcode = lead;
            w.channel = prefix;
            w.block_type = meta_type;
            w.block_length = vlq_acc;
            byte_words.push_back(w);
            left = vlq_acc;
            pay_idx = '0;
            tempo_acc = '0;
            if (left == 0) close_block();
            else st_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          w = blank_word(KIND_PAYLOAD);
          w.payload_value = b;
          byte_words.push_back(w);
          if (lead == LEAD_META) begin
            if (meta_type == META_PREFIX && pay_idx == 2'd0) prefix = b;
            if (meta_type == META_TEMPO && pay_idx < 2'd3) tempo_acc = {tempo_acc[15:0], b};
          end
          if (pay_idx < 2'd3) pay_idx = pay_idx + 2'd1;
          left = left - 28'd1;
          if (left == 0) close_block();
        end
        default: st_phase = PH_ERROR;
      endcase
      // final byte with something still open
      if (fin && !ended && st_phase != PH_ERROR && (st_phase != PH_DELTA || vlq_cnt != 0)) begin
        if (st_phase == PH_PAYLOAD) raise_error(ERR_TOO_LONG);
        else raise_error(ERR_TRUNCATED);
      end
    end
    if (byte_words.size() > 0) byte_words[byte_words.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- word compare
  function automatic string diff_fields(res_t e, res_t a);
    string s = "";
    if (e.kind !== a.kind) s = {s, " kind"};
    if (e.ticks !== a.ticks) s = {s, " ticks"};
    if (e.opcode !== a.opcode) s = {s, " opcode"};
    if (e.channel !== a.channel) s = {s, " channel"};
    if (e.data_a !== a.data_a) s = {s, " data_a"};
    if (e.data_b !== a.data_b) s = {s, " data_b"};
    if (e.block_type !== a.block_type) s = {s, " block_type"};
    if (e.block_length !== a.block_length) s = {s, " block_length"};
    if (e.payload_value !== a.payload_value) s = {s, " payload_value"};
    if (e.tempo_us !== a.tempo_us) s = {s, " tempo_us"};
    if (e.error_code !== a.error_code) s = {s, " error_code"};
    if (e.last !== a.last) s = {s, " last"};
    return s;
  endfunction

  function automatic string show_word(res_t w);
    return $sformatf("kind=%0d ticks=%h op=%h ch=%h a=%h b=%h type=%h len=%h pay=%h %s",
                     w.kind, w.ticks, w.opcode, w.channel, w.data_a, w.data_b,
                     w.block_type, w.block_length, w.payload_value,
                     $sformatf("tempo=%h err=%0d last=%b", w.tempo_us, w.error_code, w.last));
  endfunction

  // predict on every accepted byte, check every accepted result word
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    string bad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        parse_track_byte(in_tdata, in_tuser, in_tlast);
        if (cur_item.typed) begin
          want = blank_word(cur_item.tkind);
          want.ticks = cur_item.tticks;
          want.error_code = cur_item.terr;
          want.last = 1'b1;
          expected_words.push_back(want);
        end else begin
          foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
        end
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.ticks = out_tdata[27:0];
        got.opcode = out_tdata[35:28];
        got.channel = out_tdata[43:36];
        got.data_a = out_tdata[51:44];
        got.data_b = out_tdata[59:52];
        got.block_type = out_tdata[67:60];
        got.block_length = out_tdata[95:68];
        got.payload_value = out_tdata[103:96];
        got.tempo_us = out_tdata[127:104];
        got.error_code = errc_t'(out_tdata[129:128]);
        got.last = out_tlast;
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: %s", show_word(got));
        end else begin
          want = expected_words.pop_front();
          bad = diff_fields(want, got);
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch on word %0d:%s", words_checked, bad);
              $display("  expected %s", show_word(want));
              $display("  actual   %s", show_word(got));
            end
          end
        end
        if (got.kind <= KIND_ERROR) kind_seen[got.kind]++;
        words_checked++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
             QUIET_LIMIT, expected_words.size());
    $display("Regression FAIL");
    $finish;
  end

  // receiver backpressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------- track generator
  bit         start_pending;
  logic [7:0] gen_status;

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] rnd7();
    return 7'($urandom_range(127));
  endfunction

  function automatic item_t row(logic [7:0] b, logic s, logic f);
    item_t it;
    it = '0;
    it.data = b;
    it.start = s;
    it.fin = f;
    return it;
  endfunction

  function automatic item_t typed_row(logic [7:0] b, logic s, logic f, kind_t k,
                                      logic [27:0] t, errc_t c);
    item_t it;
    it = row(b, s, f);
    it.typed = 1'b1;
    it.tkind = k;
    it.tticks = t;
    it.terr = c;
    return it;
  endfunction

  // a stray byte or a stray final mark now and then
  task automatic put(logic [7:0] b);
    if (!start_pending && $urandom_range(99) == 0) stim_q.push_back(row(rnd8(), 1'b0, 1'b0));
    stim_q.push_back(row(b, start_pending, $urandom_range(199) == 0));
    start_pending = 1'b0;
  endtask

  task automatic mark_end();
    stim_q[stim_q.size() - 1].fin = 1'b1;
  endtask

  task automatic put_delta();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 3) begin
      repeat (4) put({1'b1, rnd7()});
    end else if (r < 38) begin
      put(8'h00);
    end else begin
      r = $urandom_range(99);
      n = (r < 55) ? 1 : (r < 75) ? 2 : (r < 90) ? 3 : 4;
      repeat (n - 1) put({1'b1, rnd7()});
      put({1'b0, rnd7()});
    end
  endtask

  task automatic put_len(logic [27:0] len);
    if (len < 128) begin
      if ($urandom_range(99) < 15) put(8'h80);
      put({1'b0, len[6:0]});
    end else begin
      put({1'b1, len[27:21]});
      put({1'b1, len[20:14]});
      put({1'b1, len[13:7]});
      put({1'b0, len[6:0]});
    end
  endtask

  task automatic put_event();
    int r;
    int n;
    logic [7:0] st;
    logic zeros;
    r = $urandom_range(99);
    if (r < 60) begin
      // channel event, with running status some of the time
      if (gen_status != 8'h00 && $urandom_range(99) < 35) begin
        st = gen_status;
        put({1'b0, rnd7()});
      end else begin
        st = {4'($urandom_range(14, 8)), 4'($urandom_range(15))};
        gen_status = st;
        put(st);
        put(($urandom_range(99) < 10) ? rnd8() : {1'b0, rnd7()});
      end
      if (st[7:4] != HI_PROG && st[7:4] != HI_PRESS) begin
        if (st[7:4] == HI_NOTE_ON && $urandom_range(99) < 25) put(8'h00);
        else put(($urandom_range(99) < 10) ? rnd8() : {1'b0, rnd7()});
      end
    end else if (r < 70) begin
      gen_status = 8'h00;
      put($urandom_range(1) ? LEAD_SYSEX : LEAD_ESC);
      n = $urandom_range(5);
      put_len(28'(n));
      repeat (n) put(rnd8());
    end else if (r < 95) begin
      gen_status = 8'h00;
      put(LEAD_META);
      zeros = 1'b0;
      r = $urandom_range(99);
      if (r < 25) begin
        put(META_PREFIX);
        n = $urandom_range(2);
      end else if (r < 57) begin
        put(META_TEMPO);
        n = ($urandom_range(99) < 70) ? 3 : $urandom_range(5);
        zeros = ($urandom_range(99) < 15);
      end else if (r < 59) begin
        put(META_EOT);
        n = 0;
      end else begin
        put(rnd8());
        n = $urandom_range(4);
      end
      put_len(28'(n));
      repeat (n) put(zeros ? 8'h00 : rnd8());
    end else begin
      put(($urandom_range(99) < 60) ? 8'($urandom_range(254, 241)) : rnd8());
    end
  endtask

  task automatic gen_track(bit first);
    int r;
    logic [27:0] len;
    start_pending = first || ($urandom_range(99) >= 5);
    gen_status = 8'h00;
    repeat ($urandom_range(10, 1)) begin
      put_delta();
      put_event();
    end
    put_delta();
    r = $urandom_range(99);
    if (r < 60) begin
      put(LEAD_META);
      put(META_EOT);
      put(8'h00);
    end else if (r < 84 && r >= 72) begin
      // cut inside a channel event
      put({HI_NOTE_ON, 4'($urandom_range(15))});
      if ($urandom_range(1)) put({1'b0, rnd7()});
    end else if (r >= 84 && r < 92) begin
      // long block cut inside its payload
      len = ($urandom_range(3) == 0) ? 28'hfffffff : 28'($urandom);
      if (len < 128) len = len + 28'd128;
      put(LEAD_SYSEX);
      put_len(len);
      repeat ($urandom_range(3, 1)) put(rnd8());
    end else if (r >= 92) begin
      // length with too many bytes
      put(LEAD_META);
      put(rnd8());
      repeat (4) put({1'b1, rnd7()});
    end
    mark_end();
  endtask

  // ---------------------------------------------------------------- driver
  initial begin : driver
    item_t directed_rows [DIR_ROWS];
    item_t it;
    int total;
    int mode;
    clear_parser();
    directed_rows = '{
      // data byte with no status
      row(8'h00, 1, 0), typed_row(8'h40, 0, 0, KIND_ERROR, 28'd0, ERR_NO_STATUS),
      // delta time with a fourth continuation byte
      row(8'hff, 1, 0), row(8'hff, 0, 0), row(8'hff, 0, 0),
      typed_row(8'hff, 0, 0, KIND_ERROR, 28'd0, ERR_TOO_LONG),
      // longest delta time
      row(8'hff, 1, 0), row(8'hff, 0, 0), row(8'hff, 0, 0),
      typed_row(8'h7f, 0, 0, KIND_DELAY, 28'hfffffff, ERR_NO_STATUS),
      // note on at zero velocity
      row(8'h90, 0, 0), row(8'h3c, 0, 0), row(8'h00, 0, 0),
      // system status byte that is not a block lead
      row(8'h00, 0, 0), typed_row(8'hf5, 0, 0, KIND_ERROR, 28'd0, ERR_BAD_STATUS),
      // set tempo of zero
      row(8'h00, 1, 0), row(8'hff, 0, 0), row(8'h51, 0, 0), row(8'h03, 0, 0),
      row(8'h00, 0, 0), row(8'h00, 0, 0), row(8'h00, 0, 0),
      // end of track, then a byte that is ignored
      row(8'h00, 0, 0), row(8'hff, 0, 0), row(8'h2f, 0, 0), row(8'h00, 0, 0),
      row(8'h12, 0, 0),
      // track cut inside a channel event
      row(8'h00, 1, 0), row(8'h90, 0, 0),
      typed_row(8'h3c, 0, 1, KIND_ERROR, 28'd0, ERR_TRUNCATED),
      // delta time on the final byte
      row(8'h05, 1, 1),
      // track cut inside a payload
      row(8'h00, 1, 0), row(8'hf0, 0, 0), row(8'h02, 0, 0), row(8'h11, 0, 1)
    };
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    gen_track(1'b1);
    while (stim_q.size() < DIR_ROWS + RANDOM_BYTES) gen_track(1'b0);
    total = stim_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < total; i++) begin
      // idling phases: none, sender, receiver, both lightly
      mode = (i * 4) / total;
      send_idle = (mode == 1) ? 50 : (mode == 3) ? 10 : 0;
      stall_pct = (mode == 2) ? 50 : (mode == 3) ? 10 : 0;
      while ($urandom_range(99) < send_idle) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      it = stim_q[i];
      cur_item = it;
      in_tvalid <= 1'b1;
      in_tdata <= it.data;
      in_tuser <= it.start;
      in_tlast <= it.fin;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;

    // drain, then keep watching the output to catch stray words
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_words.size() != 0) fail_count++;

    $display("%0d track bytes taken (%0d directed), %0d result words checked, %0d failures",
             bytes_taken, DIR_ROWS, words_checked, fail_count);
    $display("words by kind: delay %0d channel %0d header %0d payload %0d tempo %0d end %0d error %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5], kind_seen[6]);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
